### rtl/core/complex_arith_unit_core_assert.svh
// assertion macros for the complex arithmetic unit
// used by the checker module; needs clk and rst_n in scope
`ifndef COMPLEX_ARITH_UNIT_CORE_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_CORE_ASSERT_SVH

// condition that holds at every edge out of reset
`define CAU_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define CAU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/cau_pkg.sv
// shared types and constants of the complex arithmetic unit
// no dependencies
`default_nettype none

package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_W      = PROD_W + 1;
    localparam int MAG_W      = PROD_W;
    localparam int REM_W      = 3 * DATA_WIDTH;
    localparam int QIDX_W     = $clog2(DATA_WIDTH);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [1:0]                   operation;
        logic signed [DATA_WIDTH-1:0] a_re;
        logic signed [DATA_WIDTH-1:0] a_im;
        logic signed [DATA_WIDTH-1:0] b_re;
        logic signed [DATA_WIDTH-1:0] b_im;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_re;
        logic signed [DATA_WIDTH-1:0] res_im;
        logic                         overflow;
        logic                         div_by_zero;
    } out_item_t;

    // products and short sums after the first stage
    typedef struct packed {
        logic [1:0]               op;
        logic signed [PROD_W-1:0] ac;
        logic signed [PROD_W-1:0] bd;
        logic signed [PROD_W-1:0] ad;
        logic signed [PROD_W-1:0] bc;
        logic signed [PROD_W-1:0] cc;
        logic signed [PROD_W-1:0] dd;
        logic [DATA_WIDTH:0]      s_re;
        logic [DATA_WIDTH:0]      s_im;
    } prod_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [SUM_W-1:0]  re;
        logic [SUM_W-1:0]  im;
        logic [PROD_W-1:0] den;
    } sum_t;

    typedef struct packed {
        logic [1:0]        op;
        logic              re_neg;
        logic              im_neg;
        logic [MAG_W-1:0]  re_mag;
        logic [MAG_W-1:0]  im_mag;
        logic [PROD_W-1:0] den;
    } mag_t;

    // one result part: sign, magnitude low bits, magnitude too large, remainder
    typedef struct packed {
        logic                  neg;
        logic                  big;
        logic [DATA_WIDTH-1:0] q;
        logic [REM_W-1:0]      rem;
    } lane_t;

    typedef struct packed {
        logic              is_div;
        logic              dz;
        logic [PROD_W-1:0] den;
        lane_t             re;
        lane_t             im;
    } div_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] val;
        logic                  ovf;
    } sat_t;

endpackage

`default_nettype wire

### rtl/core/cau_prod.sv
// first stage: the six operand products and the add/subtract sums
// depends on cau_pkg
`default_nettype none

module cau_prod
    import cau_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire in_item_t in_item,
    output logic          out_valid,
    output prod_t         out_prod
);

    logic  valid_reg;
    prod_t prod_reg;
    prod_t prod_next;

    always_comb
    begin
        prod_next.op = in_item.operation;
        prod_next.ac = $signed(in_item.a_re) * $signed(in_item.b_re);
        prod_next.bd = $signed(in_item.a_im) * $signed(in_item.b_im);
        prod_next.ad = $signed(in_item.a_re) * $signed(in_item.b_im);
        prod_next.bc = $signed(in_item.a_im) * $signed(in_item.b_re);
        prod_next.cc = $signed(in_item.b_re) * $signed(in_item.b_re);
        prod_next.dd = $signed(in_item.b_im) * $signed(in_item.b_im);
        if (in_item.operation == OP_SUB)
        begin
            prod_next.s_re = {in_item.a_re[DATA_WIDTH-1], in_item.a_re}
                           - {in_item.b_re[DATA_WIDTH-1], in_item.b_re};
            prod_next.s_im = {in_item.a_im[DATA_WIDTH-1], in_item.a_im}
                           - {in_item.b_im[DATA_WIDTH-1], in_item.b_im};
        end
        else
        begin
            prod_next.s_re = {in_item.a_re[DATA_WIDTH-1], in_item.a_re}
                           + {in_item.b_re[DATA_WIDTH-1], in_item.b_re};
            prod_next.s_im = {in_item.a_im[DATA_WIDTH-1], in_item.a_im}
                           + {in_item.b_im[DATA_WIDTH-1], in_item.b_im};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;

endmodule

`default_nettype wire

### rtl/core/cau_prep.sv
// stages two to four: combine products, take magnitudes, set up the divider
// depends on cau_pkg
`default_nettype none

module cau_prep
    import cau_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire prod_t in_prod,
    output logic       out_valid,
    output div_t       out_div
);

    logic [2:0] valid_reg;
    sum_t       sum_reg;
    sum_t       sum_next;
    mag_t       mag_reg;
    mag_t       mag_next;
    div_t       div_reg;
    div_t       div_next;
    logic [SUM_W-1:0] re_negated;
    logic [SUM_W-1:0] im_negated;

    function automatic lane_t make_lane(logic [1:0] op, logic neg, logic [MAG_W-1:0] mag,
                                        logic [PROD_W-1:0] den);
        lane_t            l;
        logic [MAG_W-1:0] sh;
        logic [REM_W-1:0] x;
        logic [REM_W-1:0] top;
        begin
            sh  = mag >> FRAC_BITS;
            x   = {{DATA_WIDTH{1'b0}}, mag} << FRAC_BITS;
            top = {{DATA_WIDTH{1'b0}}, den} << DATA_WIDTH;
            l.neg = neg;
            unique case (op)
                OP_MUL:
                begin
                    l.big = |sh[MAG_W-1:DATA_WIDTH];
                    l.q   = sh[DATA_WIDTH-1:0];
                    l.rem = '0;
                end
                OP_DIV:
                begin
                    // quotient needs more than the field width
                    l.big = (x >= top);
                    l.q   = '0;
                    l.rem = x;
                end
                default:
                begin
                    l.big = |mag[MAG_W-1:DATA_WIDTH];
                    l.q   = mag[DATA_WIDTH-1:0];
                    l.rem = '0;
                end
            endcase
            return l;
        end
    endfunction

    always_comb
    begin
        sum_next.op  = in_prod.op;
        sum_next.den = in_prod.cc[PROD_W-1:0] + in_prod.dd[PROD_W-1:0];
        unique case (in_prod.op)
            OP_MUL:
            begin
                sum_next.re = {in_prod.ac[PROD_W-1], in_prod.ac}
                            - {in_prod.bd[PROD_W-1], in_prod.bd};
                sum_next.im = {in_prod.ad[PROD_W-1], in_prod.ad}
                            + {in_prod.bc[PROD_W-1], in_prod.bc};
            end
            OP_DIV:
            begin
                sum_next.re = {in_prod.ac[PROD_W-1], in_prod.ac}
                            + {in_prod.bd[PROD_W-1], in_prod.bd};
                sum_next.im = {in_prod.bc[PROD_W-1], in_prod.bc}
                            - {in_prod.ad[PROD_W-1], in_prod.ad};
            end
            default:
            begin
                sum_next.re = {{(SUM_W-DATA_WIDTH-1){in_prod.s_re[DATA_WIDTH]}}, in_prod.s_re};
                sum_next.im = {{(SUM_W-DATA_WIDTH-1){in_prod.s_im[DATA_WIDTH]}}, in_prod.s_im};
            end
        endcase
    end

    always_comb
    begin
        re_negated       = ~sum_reg.re + {{(SUM_W-1){1'b0}}, 1'b1};
        im_negated       = ~sum_reg.im + {{(SUM_W-1){1'b0}}, 1'b1};
        mag_next.op      = sum_reg.op;
        mag_next.den     = sum_reg.den;
        mag_next.re_neg  = sum_reg.re[SUM_W-1];
        mag_next.im_neg  = sum_reg.im[SUM_W-1];
        mag_next.re_mag  = sum_reg.re[SUM_W-1] ? re_negated[MAG_W-1:0] : sum_reg.re[MAG_W-1:0];
        mag_next.im_mag  = sum_reg.im[SUM_W-1] ? im_negated[MAG_W-1:0] : sum_reg.im[MAG_W-1:0];
    end

    always_comb
    begin
        div_next.is_div = (mag_reg.op == OP_DIV);
        div_next.dz     = (mag_reg.op == OP_DIV) && (mag_reg.den == '0);
        div_next.den    = mag_reg.den;
        div_next.re     = make_lane(mag_reg.op, mag_reg.re_neg, mag_reg.re_mag, mag_reg.den);
        div_next.im     = make_lane(mag_reg.op, mag_reg.im_neg, mag_reg.im_mag, mag_reg.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
            mag_reg <= mag_next;
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_div   = div_reg;

endmodule

`default_nettype wire

### rtl/core/cau_div_step.sv
// one restoring division step for both result parts
// depends on cau_pkg
`default_nettype none

module cau_div_step
    import cau_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic [QIDX_W-1:0] step,
    input  wire logic              in_valid,
    input  wire div_t              in_div,
    output logic                   out_valid,
    output div_t                   out_div
);

    logic valid_reg;
    div_t div_reg;
    div_t div_next;
    logic [REM_W-1:0] den_sh;

    function automatic lane_t do_step(lane_t l, logic active, logic [REM_W-1:0] dsh,
                                      logic [QIDX_W-1:0] idx);
        lane_t r;
        begin
            r = l;
            if (active && !l.big && (l.rem >= dsh))
            begin
                r.rem    = l.rem - dsh;
                r.q[idx] = 1'b1;
            end
            return r;
        end
    endfunction

    always_comb
    begin
        den_sh   = {{DATA_WIDTH{1'b0}}, in_div.den} << step;
        div_next = in_div;
        div_next.re = do_step(in_div.re, in_div.is_div, den_sh, step);
        div_next.im = do_step(in_div.im, in_div.is_div, den_sh, step);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            div_reg <= div_next;
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;

endmodule

`default_nettype wire

### rtl/core/complex_arith_unit_core.sv
// top level of the complex arithmetic unit: pipeline and output register
// depends on cau_pkg, cau_prod, cau_prep, cau_div_step
//
//  channel | signals                    | item
//  --------+----------------------------+---------------------------------
//  op      | op_valid, op_stall, op_item | operation code and two operands
//  res     | res_valid, res_stall, res_item | result parts and flags
//
// every operation passes through the same pipeline: products, three combine stages,
// one restoring step per quotient bit (32), then saturation into res_item
// one item enters per cycle while op_stall is low; all stages move together on one enable
// op_stall is high exactly when a result waits and res_stall holds it
// reset clears the valid bits only; data registers are left as they are
`default_nettype none

module complex_arith_unit_core
    import cau_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      op_valid,
    output logic           op_stall,
    input  wire in_item_t  op_item,
    output logic           res_valid,
    input  wire logic      res_stall,
    output out_item_t      res_item
);

    // whole pipeline advances unless a held result blocks the output
    logic      en;
    logic      prod_valid;
    prod_t     prod;
    logic [DATA_WIDTH:0] chain_valid;
    div_t      chain [0:DATA_WIDTH];
    logic      res_valid_reg;
    out_item_t res_item_reg;
    out_item_t res_item_next;
    sat_t      sat_re;
    sat_t      sat_im;

    // clamp a sign/magnitude part to the field range
    function automatic sat_t saturate(lane_t l);
        sat_t                  s;
        logic [DATA_WIDTH-1:0] lim;
        logic [DATA_WIDTH-1:0] mag;
        begin
            lim   = l.neg ? SAT_MIN : SAT_MAX;
            s.ovf = l.big || (l.q > lim);
            mag   = s.ovf ? lim : l.q;
            s.val = l.neg ? (~mag + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : mag;
            return s;
        end
    endfunction

    assign en       = !(res_valid_reg && res_stall);
    assign op_stall = !en;

    cau_prod u_prod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (op_valid),
        .in_item   (op_item),
        .out_valid (prod_valid),
        .out_prod  (prod)
    );

    cau_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prod_valid),
        .in_prod   (prod),
        .out_valid (chain_valid[0]),
        .out_div   (chain[0])
    );

    // quotient bits from the top down, one per stage
    for (genvar gi = 0; gi < DATA_WIDTH; gi++)
    begin : g_div
        localparam logic [QIDX_W-1:0] STEP = QIDX_W'(DATA_WIDTH - 1 - gi);

        cau_div_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (STEP),
            .in_valid  (chain_valid[gi]),
            .in_div    (chain[gi]),
            .out_valid (chain_valid[gi+1]),
            .out_div   (chain[gi+1])
        );
    end

    always_comb
    begin
        sat_re = saturate(chain[DATA_WIDTH].re);
        sat_im = saturate(chain[DATA_WIDTH].im);
        if (chain[DATA_WIDTH].dz)
        begin
            // zero divisor: parts and overflow forced to zero
            res_item_next.res_re      = '0;
            res_item_next.res_im      = '0;
            res_item_next.overflow    = 1'b0;
            res_item_next.div_by_zero = 1'b1;
        end
        else
        begin
            res_item_next.res_re      = sat_re.val;
            res_item_next.res_im      = sat_im.val;
            res_item_next.overflow    = sat_re.ovf || sat_im.ovf;
            res_item_next.div_by_zero = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= chain_valid[DATA_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

`default_nettype wire

### rtl/core/cau_checker.sv
// port-level checks on the complex arithmetic unit, bound to the top level
// depends on cau_pkg and complex_arith_unit_core_assert.svh
`default_nettype none

`include "complex_arith_unit_core_assert.svh"

module cau_checker
    import cau_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      op_valid,
    input wire logic      op_stall,
    input wire in_item_t  op_item,
    input wire logic      res_valid,
    input wire logic      res_stall,
    input wire out_item_t res_item
);

    `CAU_ASSERT_NEXT(a_op_hold, op_valid && op_stall,
        op_valid && $stable(op_item), "stalled operand item changed")
    `CAU_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
        res_valid && $stable(res_item), "held result item changed")
    `CAU_ASSERT_ALWAYS(a_stall_link, op_stall == (res_valid && res_stall),
        "op_stall not tied to held result")
    `CAU_ASSERT_IMPL(a_dz_zero, res_valid && res_item.div_by_zero,
        (res_item.res_re == '0) && (res_item.res_im == '0) && !res_item.overflow,
        "divide by zero result not cleared")
    `CAU_ASSERT_IMPL(a_ovf_sat, res_valid && res_item.overflow,
        (res_item.res_re == SAT_MAX) || (res_item.res_re == SAT_MIN) ||
        (res_item.res_im == SAT_MAX) || (res_item.res_im == SAT_MIN),
        "overflow without saturated part")

endmodule

bind complex_arith_unit_core cau_checker u_cau_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .op_item   (op_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
);

`default_nettype wire
